### design/crmt_pkg.sv
// crmt_pkg: shared types and constants for the collective rule match table.
// Used by crmt_rule_mem, crmt_match and collective_rule_match_table_top.
package crmt_pkg;

    localparam int HIT_W  = 6;
    localparam int MASK_W = 8;

    localparam logic [MASK_W-1:0] MASK_RESET = 8'd25;

    localparam logic MODE_ADD    = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // one stored rule: the match fields only
    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [2:0]  prim;
        logic [15:0] arg;
    } rule_t;

endpackage

### design/collective_rule_match_table_top.sv
// collective_rule_match_table_top: first-match rule table over one rule memory.
// Add: the request is accepted, then its result is loaded into the output register.
// Lookup: slot 0 is issued at accept, stored rules are compared in slot order until
// the first hit or the last stored rule, then the result is loaded.
// Throughput: one request in flight; input stalls until its result is loaded.
// Reset clears the rule count and output valid, sets the mask to 25; memory not cleared.
module collective_rule_match_table_top #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // item channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             mode,
    input  logic [31:0]                      src_addr,
    input  logic [31:0]                      dst_addr,
    input  logic [2:0]                       prim_code,
    input  logic signed [15:0]               prim_arg,
    // result channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [1:0]                       status,
    output logic [crmt_pkg::HIT_W-1:0]       hit_index,
    // mask register write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [crmt_pkg::MASK_W-1:0]      cfg_data
);

    // AW: slot address bits; CW: count bits (count can equal TABLE_DEPTH)
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int PW = (AW > crmt_pkg::HIT_W) ? AW : crmt_pkg::HIT_W;

    // Sequencer: IDLE takes one request, SCAN walks the memory for a lookup,
    // DONE holds the result until the output register is free.
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t                       state_reg,      state_next;
    logic [CW-1:0]                count_reg,      count_next;
    logic [crmt_pkg::MASK_W-1:0]  mask_reg;
    crmt_pkg::rule_t              key_reg,        key_next;
    logic [CW-1:0]                issue_idx_reg,  issue_idx_next;
    logic                         cmp_valid_reg,  cmp_valid_next;
    logic [AW-1:0]                cmp_idx_reg,    cmp_idx_next;
    logic                         cmp_last_reg,   cmp_last_next;
    crmt_pkg::status_t            res_status_reg, res_status_next;
    logic [AW-1:0]                res_hit_reg,    res_hit_next;
    logic                         out_valid_reg,  out_valid_next;
    crmt_pkg::status_t            out_status_reg, out_status_next;
    logic [crmt_pkg::HIT_W-1:0]   out_hit_reg,    out_hit_next;

    logic                         in_accept;
    crmt_pkg::rule_t              in_rule;
    logic                         wr_en;
    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    crmt_pkg::rule_t              rd_rule;
    logic                         slot_hit;
    logic [PW-1:0]                res_hit_wide;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign in_rule.src  = src_addr;
    assign in_rule.dst  = dst_addr;
    assign in_rule.prim = prim_code;
    assign in_rule.arg  = prim_arg;   // kept as a raw 16-bit pattern

    assign res_hit_wide = PW'(res_hit_reg);

    // Rule storage; adds write at the current count, lookups read one slot a cycle.
    // Items are handled one at a time, so a write never overlaps a scan read.
    crmt_rule_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (in_rule),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_rule)
    );

    // Compare the rule returned this cycle against the latched key
    crmt_match u_match (
        .rule (rd_rule),
        .key  (key_reg),
        .mask (mask_reg),
        .hit  (slot_hit)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        key_next        = key_reg;
        issue_idx_next  = issue_idx_reg;
        cmp_valid_next  = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        cmp_last_next   = cmp_last_reg;
        res_status_next = res_status_reg;
        res_hit_next    = res_hit_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_hit_next    = out_hit_reg;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = issue_idx_reg[AW-1:0];

        // output register drains independently of the sequencer
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr = '0;
                if (in_accept)
                begin
                    state_next = S_DONE;
                    if (mode == crmt_pkg::MODE_ADD)
                    begin
                        if (count_reg == CW'(TABLE_DEPTH))
                        begin
                            res_status_next = crmt_pkg::ST_FULL;
                            res_hit_next    = '0;
                        end
                        else
                        begin
                            wr_en           = 1'b1;
                            res_status_next = crmt_pkg::ST_OK;
                            res_hit_next    = count_reg[AW-1:0];
                            count_next      = CW'(count_reg + CW'(1));
                        end
                    end
                    else
                    begin
                        key_next        = in_rule;
                        res_status_next = crmt_pkg::ST_MISS;
                        res_hit_next    = '0;
                        if (count_reg != '0)
                        begin
                            // issue slot 0 now, compare next cycle
                            rd_en          = 1'b1;
                            cmp_valid_next = 1'b1;
                            cmp_idx_next   = '0;
                            cmp_last_next  = (count_reg == CW'(1));
                            issue_idx_next = CW'(1);
                            state_next     = S_SCAN;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                if (cmp_valid_reg && slot_hit)
                begin
                    res_status_next = crmt_pkg::ST_OK;
                    res_hit_next    = cmp_idx_reg;
                    state_next      = S_DONE;
                end
                else if (cmp_valid_reg && cmp_last_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    // next slot; the last one was flagged when issued
                    rd_en          = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = issue_idx_reg[AW-1:0];
                    cmp_last_next  = ((issue_idx_reg + CW'(1)) == count_reg);
                    issue_idx_next = CW'(issue_idx_reg + CW'(1));
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_hit_next    = res_hit_wide[crmt_pkg::HIT_W-1:0];
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            mask_reg      <= crmt_pkg::MASK_RESET;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                mask_reg <= cfg_data;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        issue_idx_reg  <= issue_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        cmp_last_reg   <= cmp_last_next;
        res_status_reg <= res_status_next;
        res_hit_reg    <= res_hit_next;
        out_status_reg <= out_status_next;
        out_hit_reg    <= out_hit_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign hit_index = out_hit_reg;

endmodule

### design/crmt_rule_mem.sv
// crmt_rule_mem: synchronous rule storage, one write and one read port.
// Read data is registered. Depends on crmt_pkg.
module crmt_rule_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  crmt_pkg::rule_t      wr_data,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output crmt_pkg::rule_t      rd_data
);

    crmt_pkg::rule_t mem [DEPTH];
    crmt_pkg::rule_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/crmt_match.sv
// crmt_match: compares one stored rule against the lookup key.
// Argument compare is skipped when the key's primitive bit is set in the mask.
// Depends on crmt_pkg.
module crmt_match (
    input  crmt_pkg::rule_t               rule,
    input  crmt_pkg::rule_t               key,
    input  logic [crmt_pkg::MASK_W-1:0]   mask,
    output logic                          hit
);

    logic addr_eq;
    logic prim_eq;
    logic arg_ok;

    always_comb
    begin
        addr_eq = (rule.src == key.src) && (rule.dst == key.dst);
        prim_eq = (rule.prim == key.prim);
        arg_ok  = mask[key.prim] || (rule.arg == key.arg);
        hit     = addr_eq && prim_eq && arg_ok;
    end

endmodule

### bench/collective_rule_match_table_top_tb.sv
// Testbench for collective_rule_match_table_top: queued add/lookup requests with
// a scoreboard that predicts status and slot. Depends on crmt_pkg and the top.
`timescale 1ns / 1ps

module collective_rule_match_table_top_tb;

    import crmt_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_AT     = 300;   // accepted requests before the long output hold
    localparam int HOLD_LEN    = 250;   // length of that hold, counted down in hold_left
    localparam int TAIL_WAIT   = 80;    // covers a full-table scan

    // one request: mode plus the rule fields it stores or matches
    typedef struct packed {
        logic  mode;
        rule_t rule;
    } req_t;

    // one answer from the table
    typedef struct packed {
        status_t         status;
        logic [HIT_W-1:0] slot;
    } answer_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               mode = MODE_ADD;
    logic [31:0]        src_addr = '0;
    logic [31:0]        dst_addr = '0;
    logic [2:0]         prim_code = '0;
    logic signed [15:0] prim_arg = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         status;
    logic [HIT_W-1:0]   hit_index;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [MASK_W-1:0]  cfg_data = '0;

    // stimulus side
    req_t    pending_reqs[$];
    rule_t   known_rules[$];       // rules queued as adds, in table order
    logic    idle_on = 1'b1;       // random gaps and stalls enabled
    int      gap_left = 0;
    int      accepted_reqs = 0;

    // predicted table contents
    rule_t       rules[TABLE_DEPTH];
    int          rule_count = 0;
    logic [MASK_W-1:0] mask_model = MASK_RESET;
    answer_t     expected_answers[$];

    // output side
    int      stall_left = 0;
    int      hold_left = 0;
    logic    hold_done = 1'b0;
    int      mismatch_count = 0;
    int      cycle_count = 0;
    answer_t want;

    collective_rule_match_table_top #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .src_addr  (src_addr),
        .dst_addr  (dst_addr),
        .prim_code (prim_code),
        .prim_arg  (prim_arg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .hit_index (hit_index),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic req_t req_of(input logic m, input logic [31:0] s, input logic [31:0] d,
                                    input logic [2:0] p, input logic [15:0] a);
        req_t r;
        r.mode      = m;
        r.rule.src  = s;
        r.rule.dst  = d;
        r.rule.prim = p;
        r.rule.arg  = a;
        return r;
    endfunction

    // Table behavior: add appends at the next free slot or reports full;
    // lookup returns the lowest slot whose addresses and primitive match,
    // with the argument compared only when the primitive's mask bit is clear.
    function automatic answer_t table_answer(input req_t r);
        answer_t a;
        a.status = ST_MISS;
        a.slot   = '0;
        if (r.mode == MODE_ADD)
        begin
            if (rule_count >= TABLE_DEPTH)
                a.status = ST_FULL;
            else
            begin
                rules[rule_count] = r.rule;
                a.status = ST_OK;
                a.slot   = HIT_W'(rule_count);
                rule_count++;
            end
        end
        else
        begin
            for (int i = 0; i < rule_count; i++)
            begin
                if (a.status == ST_MISS && rules[i].src == r.rule.src &&
                    rules[i].dst == r.rule.dst && rules[i].prim == r.rule.prim &&
                    (mask_model[r.rule.prim] || rules[i].arg == r.rule.arg))
                begin
                    a.status = ST_OK;
                    a.slot   = HIT_W'(i);
                end
            end
        end
        return a;
    endfunction

    // rank argument: the unused marker and both extremes turn up often
    function automatic logic [15:0] pick_arg();
        case ($urandom_range(0, 5))
            0: return 16'hffff;
            1: return 16'h8000;
            2: return 16'h7fff;
            3: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_req(input req_t r);
        pending_reqs.push_back(r);
        if (r.mode == MODE_ADD && known_rules.size() < TABLE_DEPTH)
            known_rules.push_back(r.rule);
    endtask

    // Mostly requests built from rules already queued (exact, other arg, other
    // primitive, one address bit flipped); the rest is fully random noise.
    task automatic queue_random(input int n);
        req_t  r;
        int    bit_no;
        repeat (n)
        begin
            r = req_of(($urandom_range(0, 5) == 0) ? MODE_ADD : MODE_LOOKUP,
                       $urandom, $urandom, 3'($urandom_range(0, 7)), pick_arg());
            bit_no = $urandom_range(0, 31);
            if (known_rules.size() > 0 && $urandom_range(0, 9) < 8)
            begin
                r.rule = known_rules[$urandom_range(0, known_rules.size() - 1)];
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: ;
                    4, 5, 6: r.rule.arg = pick_arg();
                    7: r.rule.prim = 3'($urandom_range(0, 7));
                    8: r.rule.src[bit_no] = ~r.rule.src[bit_no];
                    default: r.rule.dst[bit_no] = ~r.rule.dst[bit_no];
                endcase
            end
            queue_req(r);
        end
    endtask

    // wait until every queued request has been answered
    task automatic wait_idle();
        do @(posedge clk);
        while (pending_reqs.size() != 0 || in_valid || expected_answers.size() != 0);
    endtask

    task automatic write_mask(input logic [MASK_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        mask_model = value;
    endtask

    task automatic note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // Request driver: holds each request until accepted, then takes the next
    // from the queue, sometimes after a short gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_answers.push_back(
                    table_answer(req_of(mode, src_addr, dst_addr, prim_code, prim_arg)));
                accepted_reqs <= accepted_reqs + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_reqs.size() > 0)
                begin
                    in_valid  <= 1'b1;
                    mode      <= pending_reqs[0].mode;
                    src_addr  <= pending_reqs[0].rule.src;
                    dst_addr  <= pending_reqs[0].rule.dst;
                    prim_code <= pending_reqs[0].rule.prim;
                    prim_arg  <= pending_reqs[0].rule.arg;
                    void'(pending_reqs.pop_front());
                    if (idle_on && $urandom_range(0, 3) == 0)
                        gap_left <= $urandom_range(1, 6);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result stall: short random bursts, plus one long hold while requests
    // keep coming so the table backs up into its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
            hold_left  <= 0;
            hold_done  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && accepted_reqs >= HOLD_AT)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 5);
        end
        else
            out_stall <= 1'b0;
    end

    // Result monitor: in-order compare against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_answers.size() == 0)
                note_mismatch($sformatf("result with none expected: status %0d slot %0d",
                                        status, hit_index));
            else
            begin
                want = expected_answers.pop_front();
                if (status !== want.status || hit_index !== want.slot)
                    note_mismatch($sformatf("expected status %0d slot %0d, got %0d slot %0d",
                                            want.status, want.slot, status, hit_index));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset mask (args ignored for codes 0, 3, 4).
        queue_req(req_of(MODE_LOOKUP, 32'h0, 32'h0, 3'd0, 16'h0));           // empty table
        queue_req(req_of(MODE_ADD, 32'h0, 32'h0, 3'd0, 16'h0));              // slot 0
        queue_req(req_of(MODE_ADD, 32'hffffffff, 32'hffffffff, 3'd7, 16'h7fff));
        queue_req(req_of(MODE_ADD, 32'h0, 32'h0, 3'd0, 16'h0));              // duplicate
        queue_req(req_of(MODE_LOOKUP, 32'h0, 32'h0, 3'd0, 16'h0));           // earlier copy wins
        queue_req(req_of(MODE_ADD, 32'hc0a80001, 32'h0a000002, 3'd3, 16'hffff));
        queue_req(req_of(MODE_LOOKUP, 32'hc0a80001, 32'h0a000002, 3'd3, 16'h0005));
        queue_req(req_of(MODE_ADD, 32'h12345678, 32'h9abcdef0, 3'd1, 16'h8000));
        queue_req(req_of(MODE_LOOKUP, 32'h12345678, 32'h9abcdef0, 3'd1, 16'h0000));
        queue_req(req_of(MODE_LOOKUP, 32'h12345678, 32'h9abcdef0, 3'd1, 16'h8000));
        queue_req(req_of(MODE_LOOKUP, 32'hffffffff, 32'hffffffff, 3'd6, 16'h7fff));
        queue_req(req_of(MODE_LOOKUP, 32'hfffffffe, 32'hffffffff, 3'd7, 16'h7fff));
        queue_req(req_of(MODE_LOOKUP, 32'hffffffff, 32'h7fffffff, 3'd7, 16'h7fff));
        queue_req(req_of(MODE_ADD, 32'h0, 32'h0, 3'd4, 16'h1234));
        queue_req(req_of(MODE_ADD, 32'h0, 32'h0, 3'd4, 16'h4321));
        queue_req(req_of(MODE_LOOKUP, 32'h0, 32'h0, 3'd4, 16'h4321));         // first of two
        queue_req(req_of(MODE_ADD, 32'h0a0a0a0a, 32'h0b0b0b0b, 3'd2, 16'h0001));
        queue_req(req_of(MODE_ADD, 32'h0a0a0a0a, 32'h0b0b0b0b, 3'd5, 16'hfffe));
        queue_req(req_of(MODE_ADD, 32'h0a0a0a0a, 32'h0b0b0b0b, 3'd6, 16'h0002));
        wait_idle();

        // No argument ignored: the two lookups above now behave differently.
        write_mask('0);
        queue_req(req_of(MODE_LOOKUP, 32'hc0a80001, 32'h0a000002, 3'd3, 16'h0005));
        queue_req(req_of(MODE_LOOKUP, 32'h0, 32'h0, 3'd4, 16'h4321));
        wait_idle();

        write_mask('1);
        queue_req(req_of(MODE_LOOKUP, 32'h12345678, 32'h9abcdef0, 3'd1, 16'h0000));
        wait_idle();

        // Random phases, each under its own mask; the table fills during the
        // second and later adds come back full. Phases 2 and 5 run without random gaps and stalls.
        for (int phase = 0; phase < 6; phase++)
        begin
            repeat (4) @(posedge clk);
            write_mask(phase == 0 ? 8'hff : phase == 1 ? 8'h00 : phase == 4 ? MASK_RESET :
                       MASK_W'($urandom_range(0, 255)));
            idle_on <= !(phase == 2 || phase == 5);
            queue_random(phase == 5 ? 250 : 200);
            wait_idle();
        end

        repeat (TAIL_WAIT) @(posedge clk);
        if (mismatch_count == 0 && expected_answers.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### collective_rule_match_table_top.f
design/crmt_pkg.sv
design/crmt_rule_mem.sv
design/crmt_match.sv
design/collective_rule_match_table_top.sv
bench/collective_rule_match_table_top_tb.sv
